// ===== sv/sscl_pkg.sv =====
// shared widths, request codes and status codes of the sparse set candidate list
// no dependencies

`default_nettype none

package sscl_pkg;

	localparam int UNIVERSE_SIZE = 1024;
	localparam int NODE_W        = $clog2(UNIVERSE_SIZE);
	localparam int CNT_W         = $clog2(UNIVERSE_SIZE + 1);

	typedef logic [NODE_W-1:0] node_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [2:0]        op_t;
	typedef logic [1:0]        status_t;

	localparam op_t OP_CLEAR       = 3'd0;
	localparam op_t OP_INSERT      = 3'd1;
	localparam op_t OP_REMOVE_NODE = 3'd2;
	localparam op_t OP_REMOVE_SLOT = 3'd3;
	localparam op_t OP_CONTAINS    = 3'd4;
	localparam op_t OP_READ_SLOT   = 3'd5;
	localparam op_t OP_SWAP        = 3'd6;

	localparam status_t ST_OK     = 2'd0;
	localparam status_t ST_ABSENT = 2'd1;
	localparam status_t ST_DUP    = 2'd2;

endpackage

`default_nettype wire

// ===== sv/sparse_set_candidate_list_core.sv =====
// sparse set of node ids: dense member array and node-to-slot map in two synchronous memories
// depends on sscl_pkg
//
// channel  valid      stall      payload
// request  in_valid   in_stall   opcode, node_id, slot_a, slot_b
// result   out_valid  out_stall  node_out, is_member, status, member_count
//
// clear, read slot and unused codes finish in state rd1; insert, contains and remove at slot in rd2;
// remove node and swap go on to rd3 or wr, but finish in rd2 on an error or a swap of a slot with
// itself. each further state is one more dependent memory read or write
// (map read, then member read, then last-slot read or second write).
// after reset all 1024 entries of both memories are zeroed, one entry a cycle, with in_stall high.
// a finished result waits in the state that made it while the output register is stalled.

`default_nettype none

module sparse_set_candidate_list_core (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire sscl_pkg::op_t     opcode,
	input  wire sscl_pkg::node_t   node_id,
	input  wire sscl_pkg::node_t   slot_a,
	input  wire sscl_pkg::node_t   slot_b,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output sscl_pkg::node_t        node_out,
	output logic                   is_member,
	output sscl_pkg::status_t      status,
	output sscl_pkg::cnt_t         member_count
);
	import sscl_pkg::*;

	localparam logic [2:0] S_INIT = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_RD1  = 3'd2;
	localparam logic [2:0] S_RD2  = 3'd3;
	localparam logic [2:0] S_RD3  = 3'd4;
	localparam logic [2:0] S_WR   = 3'd5;

	logic [2:0] state_q, state_d;
	node_t      init_idx_q;
	cnt_t       cnt_q, cnt_d;

	op_t        op_q;
	node_t      node_q, sa_q, sb_q, pos_q, na_q;

	node_t      ms_mem [UNIVERSE_SIZE];
	node_t      sn_mem [UNIVERSE_SIZE];
	node_t      ms_rdata_q, sn_rdata_q;
	logic       ms_re, sn_re, ms_we, sn_we;
	node_t      ms_raddr, sn_raddr, ms_waddr, sn_waddr, ms_wdata, sn_wdata;

	logic       fin, fin_go, out_free, member;
	cnt_t       last_pos;
	node_t      res_node;
	logic       res_member;
	status_t    res_status;

	always_ff @(posedge clk) begin
		if (ms_we)
			ms_mem[ms_waddr] <= ms_wdata;
		if (ms_re)
			ms_rdata_q <= ms_mem[ms_raddr];
	end

	always_ff @(posedge clk) begin
		if (sn_we)
			sn_mem[sn_waddr] <= sn_wdata;
		if (sn_re)
			sn_rdata_q <= sn_mem[sn_raddr];
	end

	assign in_stall = (state_q != S_IDLE);
	assign out_free = !out_valid || !out_stall;
	assign last_pos = cnt_q - CNT_W'(1);
	assign member   = ({1'b0, pos_q} < cnt_q) && (ms_rdata_q == node_q);

	always_comb begin
		state_d    = state_q;
		cnt_d      = cnt_q;
		ms_re      = 1'b0;
		sn_re      = 1'b0;
		ms_we      = 1'b0;
		sn_we      = 1'b0;
		ms_raddr   = '0;
		sn_raddr   = '0;
		ms_waddr   = '0;
		sn_waddr   = '0;
		ms_wdata   = '0;
		sn_wdata   = '0;
		fin        = 1'b0;
		res_node   = '0;
		res_member = 1'b0;
		res_status = ST_OK;
		unique case (state_q)
			S_INIT: begin
				ms_we    = 1'b1;
				sn_we    = 1'b1;
				ms_waddr = init_idx_q;
				sn_waddr = init_idx_q;
				if (init_idx_q == NODE_W'(UNIVERSE_SIZE - 1))
					state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					sn_re    = 1'b1;
					sn_raddr = node_id;
					ms_re    = 1'b1;
					ms_raddr = slot_a;
					state_d  = S_RD1;
				end
			end
			S_RD1: begin
				unique case (op_q) inside
					OP_INSERT, OP_REMOVE_NODE, OP_CONTAINS: begin
						ms_re    = 1'b1;
						ms_raddr = sn_rdata_q;
						state_d  = S_RD2;
					end
					OP_REMOVE_SLOT: begin
						ms_re    = 1'b1;
						ms_raddr = last_pos[NODE_W-1:0];
						state_d  = S_RD2;
					end
					OP_SWAP: begin
						ms_re    = 1'b1;
						ms_raddr = sb_q;
						state_d  = S_RD2;
					end
					OP_CLEAR: begin
						fin   = 1'b1;
						cnt_d = '0;
					end
					OP_READ_SLOT: begin
						fin = 1'b1;
						if ({1'b0, sa_q} < cnt_q)
							res_node = ms_rdata_q;
						else
							res_status = ST_ABSENT;
					end
					default: begin
						fin        = 1'b1;
						res_status = ST_ABSENT;
					end
				endcase
			end
			S_RD2: begin
				unique case (op_q)
					OP_INSERT: begin
						fin = 1'b1;
						if (member) begin
							res_status = ST_DUP;
							res_member = 1'b1;
						end else if (cnt_q == CNT_W'(UNIVERSE_SIZE)) begin
							res_status = ST_DUP;
						end else begin
							ms_we      = 1'b1;
							ms_waddr   = cnt_q[NODE_W-1:0];
							ms_wdata   = node_q;
							sn_we      = 1'b1;
							sn_waddr   = node_q;
							sn_wdata   = cnt_q[NODE_W-1:0];
							cnt_d      = cnt_q + CNT_W'(1);
							res_member = 1'b1;
						end
					end
					OP_CONTAINS: begin
						fin        = 1'b1;
						res_member = member;
					end
					OP_REMOVE_NODE: begin
						if (!member) begin
							fin        = 1'b1;
							res_status = ST_ABSENT;
						end else begin
							ms_re    = 1'b1;
							ms_raddr = last_pos[NODE_W-1:0];
							state_d  = S_RD3;
						end
					end
					OP_REMOVE_SLOT: begin
						fin = 1'b1;
						if ({1'b0, sa_q} < cnt_q) begin
							res_node = na_q;
							if ({1'b0, sa_q} < last_pos) begin
								ms_we    = 1'b1;
								ms_waddr = sa_q;
								ms_wdata = ms_rdata_q;
								sn_we    = 1'b1;
								sn_waddr = ms_rdata_q;
								sn_wdata = sa_q;
							end
							cnt_d = last_pos;
						end else begin
							res_status = ST_ABSENT;
						end
					end
					OP_SWAP: begin
						if (({1'b0, sa_q} < cnt_q) && ({1'b0, sb_q} < cnt_q)) begin
							if (sa_q != sb_q) begin
								ms_we    = 1'b1;
								ms_waddr = sa_q;
								ms_wdata = ms_rdata_q;
								sn_we    = 1'b1;
								sn_waddr = ms_rdata_q;
								sn_wdata = sa_q;
								state_d  = S_WR;
							end else begin
								fin = 1'b1;
							end
						end else begin
							fin        = 1'b1;
							res_status = ST_ABSENT;
						end
					end
					default: begin
						fin        = 1'b1;
						res_status = ST_ABSENT;
					end
				endcase
			end
			S_RD3: begin
				fin      = 1'b1;
				res_node = node_q;
				if ({1'b0, pos_q} < last_pos) begin
					ms_we    = 1'b1;
					ms_waddr = pos_q;
					ms_wdata = ms_rdata_q;
					sn_we    = 1'b1;
					sn_waddr = ms_rdata_q;
					sn_wdata = pos_q;
				end
				cnt_d = last_pos;
			end
			S_WR: begin
				fin      = 1'b1;
				ms_we    = 1'b1;
				ms_waddr = sb_q;
				ms_wdata = na_q;
				sn_we    = 1'b1;
				sn_waddr = na_q;
				sn_wdata = sb_q;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		fin_go = fin && out_free;
		if (fin && !out_free) begin
			ms_we   = 1'b0;
			sn_we   = 1'b0;
			cnt_d   = cnt_q;
			state_d = state_q;
		end else if (fin) begin
			state_d = S_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_INIT;
			init_idx_q <= '0;
			cnt_q      <= '0;
			out_valid  <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (state_q == S_INIT)
				init_idx_q <= init_idx_q + NODE_W'(1);
			if (fin_go)
				out_valid <= 1'b1;
			else if (!out_stall)
				out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			op_q   <= opcode;
			node_q <= node_id;
			sa_q   <= slot_a;
			sb_q   <= slot_b;
		end
		if (state_q == S_RD1) begin
			pos_q <= sn_rdata_q;
			na_q  <= ms_rdata_q;
		end
		if (fin_go) begin
			node_out     <= res_node;
			is_member    <= res_member;
			status       <= res_status;
			member_count <= cnt_d;
		end
	end

endmodule

`default_nettype wire
